### hdl/glyph_text_renderer_defines.svh
// Assertion macros for the glyph text renderer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef GLYPH_TEXT_RENDERER_DEFINES_SVH
`define GLYPH_TEXT_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS

// General property check, disabled while reset is low
`define GTR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("glyph_text_renderer: check failed");

// Implication check: cause now, effect on the next edge
`define GTR_ASSERT_NEXT(label, clk, rstn, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cause) |=> (effect)) \
        else $error("glyph_text_renderer: sequence check failed");

`else

`define GTR_ASSERT(label, clk, rstn, prop)
`define GTR_ASSERT_NEXT(label, clk, rstn, cause, effect)

`endif

`endif

### hdl/gtr_pkg.sv
// Shared types and constants for the glyph text renderer.
// No dependencies; imported by every module of the block but gtr_ram.
`timescale 1ns / 1ps

package gtr_pkg;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 72;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [7:0]  NULL_CODE     = 8'd0;
    localparam logic [7:0]  NEWLINE_CODE  = 8'd10;
    localparam logic [15:0] CHAR_ADVANCE  = 16'd8;
    localparam logic        ACTION_LOAD   = 1'b0;

    localparam logic [15:0] LINE_PITCH_RST   = 16'd1024;
    localparam logic [15:0] SCREEN_WIDTH_RST = 16'd1024;
    localparam logic [7:0]  GLYPH_STRIDE_RST = 8'd16;
    localparam logic [31:0] TEXT_COLOUR_RST  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_LINE_PITCH   = 2'd0,
        REG_SCREEN_WIDTH = 2'd1,
        REG_GLYPH_STRIDE = 2'd2,
        REG_TEXT_COLOUR  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] line_pitch;
        logic [15:0] screen_width;
        logic [7:0]  glyph_stride;
        logic [31:0] text_colour;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic red_step;
        logic ram_write;
        logic rows_run;
        logic newline;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_null;
        logic is_newline;
        logic red_last;
        logic last_moved;
    } status_t;

endpackage

### hdl/gtr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/gtr_regs.sv
// APB configuration registers of the glyph text renderer.
// Depends on gtr_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module gtr_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gtr_pkg::APB_AW-1:0]  paddr,
    input  logic [gtr_pkg::APB_DW-1:0]  pwdata,
    output logic [gtr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output gtr_pkg::cfg_t               cfg
);
    import gtr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_LINE_PITCH:   cfg_next.line_pitch   = pwdata[15:0];
                REG_SCREEN_WIDTH: cfg_next.screen_width = pwdata[15:0];
                REG_GLYPH_STRIDE: cfg_next.glyph_stride = pwdata[7:0];
                REG_TEXT_COLOUR:  cfg_next.text_colour  = pwdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_pitch   <= LINE_PITCH_RST;
            cfg_reg.screen_width <= SCREEN_WIDTH_RST;
            cfg_reg.glyph_stride <= GLYPH_STRIDE_RST;
            cfg_reg.text_colour  <= TEXT_COLOUR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_LINE_PITCH:   prdata = {16'd0, cfg_reg.line_pitch};
            REG_SCREEN_WIDTH: prdata = {16'd0, cfg_reg.screen_width};
            REG_GLYPH_STRIDE: prdata = {24'd0, cfg_reg.glyph_stride};
            REG_TEXT_COLOUR:  prdata = cfg_reg.text_colour;
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

### hdl/gtr_ctrl.sv
// Sequencing state machine of the glyph text renderer.
// Depends on gtr_pkg for the command and status structs.
`timescale 1ns / 1ps

module gtr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gtr_pkg::status_t  st,
    output gtr_pkg::cmd_t     cmd
);
    import gtr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DECODE  = 6'b000010,
        ST_REDUCE  = 6'b000100,
        ST_WRITE   = 6'b001000,
        ST_ROWS    = 6'b010000,
        ST_ADVANCE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                if (st.is_load) begin
                    state_next = ST_REDUCE;
                end else if (st.is_null) begin
                    state_next = ST_IDLE;
                end else if (st.is_newline) begin
                    cmd.newline = 1'b1;
                    state_next  = ST_IDLE;
                end else begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.red_step = 1'b1;
                if (st.red_last) begin
                    state_next = st.is_load ? ST_WRITE : ST_ROWS;
                end
            end
            ST_WRITE: begin
                cmd.ram_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_ROWS: begin
                cmd.rows_run = 1'b1;
                if (st.last_moved) begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/gtr_dpath.sv
// Datapath of the glyph text renderer: cursor, address reduction, row
// offsets, read pipeline and output register. Depends on gtr_pkg and the
// assertion macros in glyph_text_renderer_defines.svh.
`timescale 1ns / 1ps
`include "glyph_text_renderer_defines.svh"

module gtr_dpath #(
    parameter int GLYPH_STORE_DEPTH = 4096,
    parameter int GLYPH_ROWS        = 16,
    localparam int AW = (GLYPH_STORE_DEPTH > 1) ? $clog2(GLYPH_STORE_DEPTH) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gtr_pkg::cfg_t                  cfg,
    input  gtr_pkg::cmd_t                  cmd,
    output gtr_pkg::status_t               st,
    input  logic [gtr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gtr_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic                           ram_re,
    output logic [AW-1:0]                  ram_raddr,
    input  logic [7:0]                     ram_rdata
);
    import gtr_pkg::*;

    // Reduction modulo the store depth in two steps: the quotient of the
    // 16-bit address by reciprocal multiplication, then subtract q * depth.
    localparam int RED_STEPS = 2;
    localparam int RED_K     = RED_STEPS - 1;
    localparam int RKW       = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int CW        = $clog2(GLYPH_ROWS + 1);
    localparam int RSH       = 16 + AW;
    localparam int QW        = 33 - RSH;
    localparam logic [32:0] RMUL =
        33'(((64'd1 << RSH) + 64'(GLYPH_STORE_DEPTH) - 64'd1) / 64'(GLYPH_STORE_DEPTH));

    logic          act_reg;
    logic [7:0]    code_reg;
    logic [11:0]   sidx_reg;
    logic [7:0]    sbyte_reg;

    logic [15:0]   red_val_reg, red_val_next;
    logic [RKW-1:0] red_k_reg, red_k_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0]   off_reg, off_next;
    logic [CW-1:0] issue_cnt_reg, issue_cnt_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [31:0]   pend_off_reg;
    logic          pend_last_reg;
    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_off_reg;
    logic [7:0]    m_mask_reg;
    logic [31:0]   m_colour_reg;
    logic          m_last_reg;
    logic [15:0]   cursor_x_reg, cursor_x_next;
    logic [15:0]   cursor_y_reg, cursor_y_next;

    logic [15:0]   glyph_base;
    logic [31:0]   row0_base;
    logic [32:0]   quo_prod;
    logic [15:0]   quo_back;
    logic          first_step;
    logic          out_free;
    logic          move;
    logic          issue;
    logic          all_issued;
    logic [16:0]   next_x;
    logic          wrap;

    assign glyph_base = {8'd0, code_reg} * {8'd0, cfg.glyph_stride};
    assign row0_base  = {16'd0, cursor_y_reg} * {16'd0, cfg.line_pitch};
    assign quo_prod   = {17'd0, red_val_reg} * RMUL;
    assign quo_back   = 16'(quo_reg) * 16'(GLYPH_STORE_DEPTH);
    assign first_step = (red_k_reg == RKW'(RED_K));

    assign out_free   = !m_valid_reg || m_tready;
    assign move       = rd_valid_reg && out_free;
    assign all_issued = (issue_cnt_reg == CW'(GLYPH_ROWS));
    assign issue      = cmd.rows_run && !all_issued && (!rd_valid_reg || move);

    assign next_x = {1'b0, cursor_x_reg} + {1'b0, CHAR_ADVANCE};
    assign wrap   = (next_x + {1'b0, CHAR_ADVANCE}) > {1'b0, cfg.screen_width};

    assign st.is_load    = (act_reg == ACTION_LOAD);
    assign st.is_null    = (code_reg == NULL_CODE);
    assign st.is_newline = (code_reg == NEWLINE_CODE);
    assign st.red_last   = (red_k_reg == '0);
    assign st.last_moved = move && pend_last_reg;

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            code_reg  <= s_tdata[7:0];
            sidx_reg  <= s_tdata[19:8];
            sbyte_reg <= s_tdata[27:20];
            act_reg   <= s_tuser;
        end
    end

    always_comb begin
        red_val_next   = red_val_reg;
        red_k_next     = red_k_reg;
        quo_next       = quo_reg;
        off_next       = off_reg;
        issue_cnt_next = issue_cnt_reg;
        if (cmd.decode) begin
            red_val_next   = st.is_load ? {4'd0, sidx_reg} : glyph_base;
            red_k_next     = RKW'(RED_K);
            off_next       = row0_base;
            issue_cnt_next = '0;
        end else if (cmd.red_step) begin
            if (first_step) begin
                quo_next = quo_prod[32:RSH];
                off_next = off_reg + {16'd0, cursor_x_reg};
            end else begin
                red_val_next = red_val_reg - quo_back;
            end
            if (!st.red_last) begin
                red_k_next = red_k_reg - RKW'(1);
            end
        end else if (issue) begin
            red_val_next = (red_val_reg == 16'(GLYPH_STORE_DEPTH - 1)) ?
                           16'd0 : red_val_reg + 16'd1;
            off_next       = off_reg + {16'd0, cfg.line_pitch};
            issue_cnt_next = issue_cnt_reg + CW'(1);
        end
    end

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (issue) begin
            rd_valid_next = 1'b1;
        end else if (move) begin
            rd_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (move) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_comb begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.newline || (cmd.advance && wrap)) begin
            cursor_x_next = 16'd0;
            cursor_y_next = cursor_y_reg + 16'(GLYPH_ROWS);
        end else if (cmd.advance) begin
            cursor_x_next = next_x[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_k_reg     <= '0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cursor_x_reg  <= 16'd0;
            cursor_y_reg  <= 16'd0;
        end else begin
            red_k_reg     <= red_k_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            m_valid_reg   <= m_valid_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
        end
    end

    // Payload registers: reduction value, offsets, pending row, output word
    always_ff @(posedge aclk) begin
        red_val_reg <= red_val_next;
        quo_reg     <= quo_next;
        off_reg     <= off_next;
        if (issue) begin
            pend_off_reg  <= off_reg;
            pend_last_reg <= (issue_cnt_reg == CW'(GLYPH_ROWS - 1));
        end
        if (move) begin
            m_off_reg    <= pend_off_reg;
            m_mask_reg   <= ram_rdata;
            m_colour_reg <= cfg.text_colour;
            m_last_reg   <= pend_last_reg;
        end
    end

    assign ram_we    = cmd.ram_write;
    assign ram_waddr = red_val_reg[AW-1:0];
    assign ram_wdata = sbyte_reg;
    assign ram_re    = issue;
    assign ram_raddr = red_val_reg[AW-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_colour_reg, m_mask_reg, m_off_reg};
    assign m_tlast  = m_last_reg;

    `GTR_ASSERT(a_addr_in_range, aclk, aresetn, cmd.rows_run |-> (17'(red_val_reg) < 17'(GLYPH_STORE_DEPTH)))
    `GTR_ASSERT_NEXT(a_last_lands, aclk, aresetn, st.last_moved, m_valid_reg && m_last_reg)
    `GTR_ASSERT_NEXT(a_pending_held, aclk, aresetn, rd_valid_reg && !out_free, rd_valid_reg)
    `GTR_ASSERT(a_line_step_homes_x, aclk, aresetn, !$stable(cursor_y_reg) |-> (cursor_x_reg == 16'd0))

endmodule

### hdl/glyph_text_renderer.sv
// Top level of the glyph text renderer: stream ports, APB registers, glyph RAM.
// Depends on gtr_pkg, gtr_regs, gtr_ctrl, gtr_dpath and gtr_ram.
`timescale 1ns / 1ps

// Text console for 8x16 bitmap fonts. Each input word is either a glyph
// store load (tuser low: write store_byte at store_index) or a print (tuser
// high: char_code). Code 0 is dropped, newline homes the cursor and moves it
// down one text line; any other code yields GLYPH_ROWS output words, one per
// glyph row, carrying the pixel offset of the row start (x + (y+row)*pitch,
// relative to the framebuffer base), the 8-pixel mask with bit 7 leftmost,
// the text colour and tlast on the final row. Then the cursor advances by 8
// and wraps to the next text line when x+16 exceeds screen_width. One input
// word is handled at a time. The glyph address is reduced modulo the store
// depth in two steps (reciprocal multiplication for the quotient, then a
// subtract). The glyph RAM read port delivers one row per cycle while the
// output register is free to take it. The output register lets the next
// word be accepted while the last row of the previous glyph still waits on
// m_tready. The glyph store has no reset; glyphs must be loaded before they
// are printed.
module glyph_text_renderer #(
    parameter int GLYPH_STORE_DEPTH = 4096,
    parameter int GLYPH_ROWS        = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] char_code, [19:8] store_index, [27:20] store_byte, [31:28] zero
    input  logic [gtr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] action: 0 load glyph store byte, 1 print character
    input  logic                           s_tuser,
    // Row stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] pixel_offset, [39:32] row_mask, [71:40] pixel_colour
    output logic [gtr_pkg::M_TDATA_W-1:0]  m_tdata,
    // last_row
    output logic                           m_tlast,
    // Configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gtr_pkg::APB_AW-1:0]     paddr,
    input  logic [gtr_pkg::APB_DW-1:0]     pwdata,
    output logic [gtr_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import gtr_pkg::*;

    localparam int AW = (GLYPH_STORE_DEPTH > 1) ? $clog2(GLYPH_STORE_DEPTH) : 1;

    cfg_t          cfg;
    cmd_t          cmd;
    status_t       st;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Register file: line_pitch, screen_width, glyph_stride, text_colour
    gtr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accept, decode, reduce address, write or run rows, advance
    gtr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Cursor, offset arithmetic, read pipeline and output register
    gtr_dpath #(
        .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH),
        .GLYPH_ROWS        (GLYPH_ROWS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Glyph store: one byte per glyph row
    gtr_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_STORE_DEPTH)
    ) u_glyph_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
